// ===== rtl/hvo_pkg.sv =====
// hvo_pkg: shared types and constants for the hexahedron vertex order unit.
// Used by every module under rtl/; depends on nothing.
package hvo_pkg;

  localparam int VERTEX_BITS      = 32;
  localparam int PORT_BITS        = 32;
  localparam int FACES_PER_CELL   = 6;
  localparam int CORNERS_PER_FACE = 4;
  localparam int HEXA_SLOTS       = 8;

  localparam int FACE_CNT_BITS = $clog2(FACES_PER_CELL);
  localparam int EDGE_BITS     = $clog2(CORNERS_PER_FACE);
  localparam int SLOT_BITS     = $clog2(HEXA_SLOTS);

  // face queue between front and back; depth must stay a power of two
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  typedef logic [VERTEX_BITS-1:0]   vid_t;
  typedef logic [FACE_CNT_BITS-1:0] face_cnt_t;
  typedef logic [EDGE_BITS-1:0]     edge_t;
  typedef logic [SLOT_BITS-1:0]     slot_t;
  typedef logic [FIFO_PTR_BITS-1:0] fptr_t;
  typedef logic [FIFO_CNT_BITS-1:0] fcnt_t;

  // one classified face word
  typedef struct packed {
    vid_t [CORNERS_PER_FACE-1:0] corner;
    logic                        flip;
    logic                        first;
    logic                        last;
  } face_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // finished cell handed to the emitter
  typedef struct packed {
    vid_t [HEXA_SLOTS-1:0]       vert;
    logic [CORNERS_PER_FACE-1:0] bad;
  } cell_t;

endpackage

// ===== rtl/hvo_front.sv =====
// hvo_front: accepts face words, masks vertex ids and tags each face with
// its place in the cell. Depends on hvo_pkg.
module hvo_front import hvo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [PORT_BITS-1:0] in_corner_a,
  input  logic [PORT_BITS-1:0] in_corner_b,
  input  logic [PORT_BITS-1:0] in_corner_c,
  input  logic [PORT_BITS-1:0] in_corner_d,
  input  logic               in_face_flipped,
  input  fifo_stat_t         q_stat,
  output logic               q_push,
  output face_t              q_word
);

  face_cnt_t count_r, count_nxt;
  logic      is_last;

  assign in_full = q_stat.full;
  assign q_push  = in_push && !q_stat.full;
  assign is_last = (count_r == face_cnt_t'(FACES_PER_CELL - 1));

  always_comb begin
    q_word.corner[0] = in_corner_a[VERTEX_BITS-1:0];
    q_word.corner[1] = in_corner_b[VERTEX_BITS-1:0];
    q_word.corner[2] = in_corner_c[VERTEX_BITS-1:0];
    q_word.corner[3] = in_corner_d[VERTEX_BITS-1:0];
    q_word.flip      = in_face_flipped;
    q_word.first     = (count_r == '0);
    q_word.last      = is_last;
  end

  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      count_nxt = is_last ? '0 : count_r + face_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/hvo_fifo.sv =====
// hvo_fifo: short face queue that decouples the front from the edge scanner.
// Depends on hvo_pkg.
module hvo_fifo import hvo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  face_t      wr_word,
  input  logic       pop,
  output face_t      rd_word,
  output fifo_stat_t stat
);

  face_t mem_r [FIFO_DEPTH];
  fptr_t wr_ptr_r, rd_ptr_r;
  fcnt_t count_r, count_nxt;
  logic  do_push, do_pop;

  assign stat.full  = (count_r == fcnt_t'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_word    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + fcnt_t'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - fcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + fptr_t'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + fptr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

// ===== rtl/hvo_back.sv =====
// hvo_back: edge scanner. Loads the bottom corners from face 0, then walks the edges
// of faces 1 to 5 one per cycle, holding on the last edge of face 5 until the emitter
// takes the cell, tracking each corner's outside neighbour. Depends on hvo_pkg.
module hvo_back import hvo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_stat_t q_stat,
  input  face_t      q_word,
  output logic       q_pop,
  output logic       cell_valid,
  output cell_t      cell_word,
  input  logic       cell_ready
);

  localparam int NC = CORNERS_PER_FACE;

  logic    busy_r, busy_nxt;
  logic    last_r;
  edge_t   edge_r;
  vid_t [NC-1:0] face_r;
  vid_t [NC-1:0] corner_r;
  logic [NC-1:0] have_r, other_r;
  vid_t [NC-1:0] best_r;

  logic [NC-1:0] have_m, other_m;
  vid_t [NC-1:0] best_m;
  logic [NC-1:0] eq0, eq1, cand_v;
  vid_t          p0, p1;
  logic          onb0, onb1, done_face;

  assign done_face  = busy_r && (edge_r == edge_t'(NC - 1)) && (!last_r || cell_ready);
  assign q_pop      = !q_stat.empty && (!busy_r || done_face);
  assign cell_valid = done_face && last_r;

  // one edge per cycle unless stalled on the last edge; an edge can hand corner k at most one candidate,
  // since a matching end is itself on the bottom face
  always_comb begin
    p0   = face_r[edge_r];
    p1   = face_r[edge_r + edge_t'(1)];
    for (int k = 0; k < NC; k++) begin
      eq0[k] = (p0 == corner_r[k]);
      eq1[k] = (p1 == corner_r[k]);
    end
    onb0 = |eq0;
    onb1 = |eq1;
    have_m  = have_r;
    other_m = other_r;
    best_m  = best_r;
    for (int k = 0; k < NC; k++) begin
      cand_v[k] = (eq0[k] && !onb1) || (eq1[k] && !onb0);
      // merge is idempotent, so repeating the last edge while stalled is harmless
      if (busy_r && cand_v[k]) begin
        if (!have_r[k]) begin
          have_m[k] = 1'b1;
          best_m[k] = eq0[k] ? p1 : p0;
        end else if ((eq0[k] ? p1 : p0) != best_r[k]) begin
          other_m[k] = 1'b1;
          if ((eq0[k] ? p1 : p0) < best_r[k]) begin
            best_m[k] = eq0[k] ? p1 : p0;
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      cell_word.vert[k]      = corner_r[k];
      cell_word.vert[NC + k] = have_m[k] ? best_m[k] : '0;
      cell_word.bad[k]       = !(have_m[k] && !other_m[k]);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (q_pop) begin
      busy_nxt = !q_word.first;
    end else if (done_face) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      edge_r  <= '0;
      have_r  <= '0;
      other_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (q_pop) begin
        edge_r <= '0;
      end else if (busy_r && (edge_r != edge_t'(NC - 1))) begin
        edge_r <= edge_r + edge_t'(1);
      end
      if (q_pop && q_word.first) begin
        have_r  <= '0;
        other_r <= '0;
      end else begin
        have_r  <= have_m;
        other_r <= other_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_m;
    if (q_pop) begin
      face_r <= q_word.corner;
      last_r <= q_word.last;
      if (q_word.first) begin
        corner_r[0] <= q_word.corner[0];
        corner_r[1] <= q_word.flip ? q_word.corner[3] : q_word.corner[1];
        corner_r[2] <= q_word.corner[2];
        corner_r[3] <= q_word.flip ? q_word.corner[1] : q_word.corner[3];
      end
    end
  end

endmodule

// ===== rtl/hvo_emit.sv =====
// hvo_emit: holds one finished cell and hands out its eight slot words in
// order. Depends on hvo_pkg.
module hvo_emit import hvo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cell_valid,
  input  cell_t                cell_word,
  output logic                 cell_ready,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [PORT_BITS-1:0] out_vertex_out,
  output logic [SLOT_BITS-1:0] out_slot,
  output logic                 out_bad_topology,
  output logic                 out_run_last
);

  logic  valid_r;
  slot_t slot_r;
  vid_t [HEXA_SLOTS-1:0]       vert_r;
  logic [CORNERS_PER_FACE-1:0] bad_r;
  logic  take, at_end;

  assign take       = out_pop && valid_r;
  assign at_end     = (slot_r == slot_t'(HEXA_SLOTS - 1));
  assign cell_ready = !valid_r || (take && at_end);

  assign out_empty        = !valid_r;
  assign out_vertex_out   = PORT_BITS'(vert_r[slot_r]);
  assign out_slot         = slot_r;
  // bottom slots never flag
  assign out_bad_topology = slot_r[SLOT_BITS-1] && bad_r[slot_r[SLOT_BITS-2:0]];
  assign out_run_last     = at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else if (cell_valid && cell_ready) begin
      valid_r <= 1'b1;
      slot_r  <= '0;
    end else if (take) begin
      slot_r <= slot_r + slot_t'(1);
      if (at_end) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cell_valid && cell_ready) begin
      vert_r <= cell_word.vert;
      bad_r  <= cell_word.bad;
    end
  end

endmodule

// ===== rtl/hexa_vertex_order_unit.sv =====
// hexa_vertex_order_unit: orders the eight vertices of a hexahedral cell
// from its six quad faces. The edge scanner walks one face edge per cycle
// while not stalled and takes the next face as it ends the last edge of the
// current one; face 0 is only loaded. The eight slot words then leave at one
// per cycle while out_pop is held. Reset (sync, rst_n low) empties the
// face queue, restarts face counting at face 0 and drops any held cell.
module hexa_vertex_order_unit import hvo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [PORT_BITS-1:0] in_corner_a,
  input  logic [PORT_BITS-1:0] in_corner_b,
  input  logic [PORT_BITS-1:0] in_corner_c,
  input  logic [PORT_BITS-1:0] in_corner_d,
  input  logic                 in_face_flipped,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [PORT_BITS-1:0] out_vertex_out,
  output logic [SLOT_BITS-1:0] out_slot,
  output logic                 out_bad_topology,
  output logic                 out_run_last
);

  fifo_stat_t q_stat;
  face_t      q_wr_word, q_rd_word;
  logic       q_push, q_pop;
  logic       cell_valid, cell_ready;
  cell_t      cell_word;

  hvo_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_corner_a     (in_corner_a),
    .in_corner_b     (in_corner_b),
    .in_corner_c     (in_corner_c),
    .in_corner_d     (in_corner_d),
    .in_face_flipped (in_face_flipped),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_word          (q_wr_word)
  );

  hvo_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_word (q_wr_word),
    .pop     (q_pop),
    .rd_word (q_rd_word),
    .stat    (q_stat)
  );

  hvo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_word     (q_rd_word),
    .q_pop      (q_pop),
    .cell_valid (cell_valid),
    .cell_word  (cell_word),
    .cell_ready (cell_ready)
  );

  hvo_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .cell_valid       (cell_valid),
    .cell_word        (cell_word),
    .cell_ready       (cell_ready),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_vertex_out   (out_vertex_out),
    .out_slot         (out_slot),
    .out_bad_topology (out_bad_topology),
    .out_run_last     (out_run_last)
  );

endmodule

// ===== bench/hexa_vertex_order_checker.sv =====
// Checker for hexa_vertex_order_unit: watches the face and slot channels,
// predicts the slot words of each cell and compares them in order.
// Depends on hvo_pkg for widths and types.
module hexa_vertex_order_checker import hvo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [PORT_BITS-1:0] in_corner_a,
  input  logic [PORT_BITS-1:0] in_corner_b,
  input  logic [PORT_BITS-1:0] in_corner_c,
  input  logic [PORT_BITS-1:0] in_corner_d,
  input  logic                 in_face_flipped,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic [PORT_BITS-1:0] out_vertex_out,
  input  logic [SLOT_BITS-1:0] out_slot,
  input  logic                 out_bad_topology,
  input  logic                 out_run_last,
  output int unsigned          pending_words,
  output int unsigned          fail_count
);

  typedef struct packed {
    logic [PORT_BITS-1:0] vertex;
    slot_t                slot;
    logic                 bad;
    logic                 last;
  } slot_word_t;

  slot_word_t expected_slots[$];
  vid_t       cell_faces [FACES_PER_CELL*CORNERS_PER_FACE];
  int         face_idx;
  logic       bottom_flip;

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // orders the bottom face, then finds each corner's neighbour off it (the lowest if several; none or several flag bad)
  task automatic order_cell();
    vid_t       hexa [HEXA_SLOTS];
    logic       bad [HEXA_SLOTS];
    vid_t       tmp, p0, p1, w, best;
    logic       have, other, hit, outside;
    slot_word_t sw;
    int         k, e, c;
    for (k = 0; k < CORNERS_PER_FACE; k++) begin
      hexa[k] = cell_faces[k];
      bad[k]  = 1'b0;
    end
    if (bottom_flip) begin
      tmp     = hexa[1];
      hexa[1] = hexa[3];
      hexa[3] = tmp;
    end
    for (k = 0; k < CORNERS_PER_FACE; k++) begin
      have  = 1'b0;
      other = 1'b0;
      best  = '0;
      for (e = 0; e < FACES_PER_CELL*CORNERS_PER_FACE; e++) begin
        p0 = cell_faces[e];
        p1 = cell_faces[(e/CORNERS_PER_FACE)*CORNERS_PER_FACE + (e+1)%CORNERS_PER_FACE];
        for (c = 0; c < 2; c++) begin
          hit     = (c == 0) ? (p0 == hexa[k]) : (p1 == hexa[k]);
          w       = (c == 0) ? p1 : p0;
          outside = (w != hexa[0]) && (w != hexa[1]) && (w != hexa[2]) && (w != hexa[3]);
          if (hit && outside) begin
            if (!have) begin
              have = 1'b1;
              best = w;
            end else if (w != best) begin
              other = 1'b1;
              if (w < best) best = w;
            end
          end
        end
      end
      hexa[CORNERS_PER_FACE+k] = have ? best : '0;
      bad[CORNERS_PER_FACE+k]  = !(have && !other);
    end
    for (k = 0; k < HEXA_SLOTS; k++) begin
      sw.vertex = PORT_BITS'(hexa[k]);
      sw.slot   = slot_t'(k);
      sw.bad    = bad[k];
      sw.last   = (k == HEXA_SLOTS-1);
      expected_slots = {expected_slots, sw};
    end
  endtask

  always @(posedge clk) begin
    slot_word_t want;
    if (!rst_n) begin
      face_idx    = 0;
      bottom_flip = 1'b0;
      expected_slots.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_slots.size() == 0) begin
          report($sformatf("unexpected slot word vertex=%0h slot=%0d",
                           out_vertex_out, out_slot));
        end else begin
          want = expected_slots.pop_front();
          if (out_vertex_out !== want.vertex)
            report($sformatf("slot %0d vertex got %0h exp %0h", want.slot,
                             out_vertex_out, want.vertex));
          if (out_slot !== want.slot)
            report($sformatf("slot got %0d exp %0d", out_slot, want.slot));
          if (out_bad_topology !== want.bad)
            report($sformatf("slot %0d bad_topology got %b exp %b", want.slot,
                             out_bad_topology, want.bad));
          if (out_run_last !== want.last)
            report($sformatf("slot %0d run_last got %b exp %b", want.slot,
                             out_run_last, want.last));
        end
      end
      if (in_push && !in_full) begin
        cell_faces[face_idx*CORNERS_PER_FACE+0] = in_corner_a[VERTEX_BITS-1:0];
        cell_faces[face_idx*CORNERS_PER_FACE+1] = in_corner_b[VERTEX_BITS-1:0];
        cell_faces[face_idx*CORNERS_PER_FACE+2] = in_corner_c[VERTEX_BITS-1:0];
        cell_faces[face_idx*CORNERS_PER_FACE+3] = in_corner_d[VERTEX_BITS-1:0];
        if (face_idx == 0) bottom_flip = in_face_flipped;
        if (face_idx == FACES_PER_CELL-1) begin
          face_idx = 0;
          order_cell();
        end else begin
          face_idx++;
        end
      end
    end
    pending_words <= expected_slots.size();
  end

endmodule

// ===== bench/hexa_vertex_order_unit_tb.sv =====
// Top of the hexa_vertex_order_unit bench: clock, reset, face stimulus and
// random pop stalls; depends on hvo_pkg, the unit and hexa_vertex_order_checker.
module hexa_vertex_order_unit_tb;
  import hvo_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [PORT_BITS-1:0] in_corner_a = '0;
  logic [PORT_BITS-1:0] in_corner_b = '0;
  logic [PORT_BITS-1:0] in_corner_c = '0;
  logic [PORT_BITS-1:0] in_corner_d = '0;
  logic                 in_face_flipped = 1'b0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [PORT_BITS-1:0] out_vertex_out;
  logic [SLOT_BITS-1:0] out_slot;
  logic                 out_bad_topology;
  logic                 out_run_last;
  int unsigned          pending_words;
  int unsigned          fail_count;
  bit                   steady = 1'b0;
  vid_t                 cube_ids [HEXA_SLOTS];

  hexa_vertex_order_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_corner_a(in_corner_a), .in_corner_b(in_corner_b),
    .in_corner_c(in_corner_c), .in_corner_d(in_corner_d),
    .in_face_flipped(in_face_flipped),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_vertex_out(out_vertex_out), .out_slot(out_slot),
    .out_bad_topology(out_bad_topology), .out_run_last(out_run_last)
  );

  hexa_vertex_order_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_corner_a(in_corner_a), .in_corner_b(in_corner_b),
    .in_corner_c(in_corner_c), .in_corner_d(in_corner_d),
    .in_face_flipped(in_face_flipped),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_vertex_out(out_vertex_out), .out_slot(out_slot),
    .out_bad_topology(out_bad_topology), .out_run_last(out_run_last),
    .pending_words(pending_words), .fail_count(fail_count)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // corner indexes of the six cube faces, bottom 0-3, top 4-7 above them
  function automatic logic [11:0] face_corners(int f);
    case (f)
      0:       return {3'd3, 3'd2, 3'd1, 3'd0};
      1:       return {3'd5, 3'd6, 3'd7, 3'd4};
      2:       return {3'd1, 3'd5, 3'd4, 3'd0};
      3:       return {3'd2, 3'd6, 3'd5, 3'd1};
      4:       return {3'd3, 3'd7, 3'd6, 3'd2};
      default: return {3'd0, 3'd4, 3'd7, 3'd3};
    endcase
  endfunction

  task automatic send_face(input vid_t a, input vid_t b, input vid_t c, input vid_t d,
                           input logic flip);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_corner_a     <= PORT_BITS'(a);
    in_corner_b     <= PORT_BITS'(b);
    in_corner_c     <= PORT_BITS'(c);
    in_corner_d     <= PORT_BITS'(d);
    in_face_flipped <= flip;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // hold off until every slot word owed so far has been popped
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // faces of one cube in random order, rotation and direction
  task automatic send_cube(input bit narrow, input bit broken);
    int          order [FACES_PER_CELL];
    vid_t        q [CORNERS_PER_FACE];
    logic [11:0] fc;
    int          i, j, t, r, k, pos, bad_face;
    bit          rev;
    for (i = 0; i < HEXA_SLOTS; i++)
      cube_ids[i] = narrow ? vid_t'($urandom_range(0, 11)) : vid_t'($urandom);
    for (i = 0; i < FACES_PER_CELL; i++) order[i] = i;
    for (i = FACES_PER_CELL-1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    bad_face = broken ? $urandom_range(0, FACES_PER_CELL-1) : FACES_PER_CELL;
    for (i = 0; i < FACES_PER_CELL; i++) begin
      fc  = face_corners(order[i]);
      r   = $urandom_range(0, 3);
      rev = 1'($urandom_range(0, 1));
      for (k = 0; k < CORNERS_PER_FACE; k++) begin
        pos  = rev ? (r + CORNERS_PER_FACE - k) % CORNERS_PER_FACE : (r + k) % CORNERS_PER_FACE;
        q[k] = cube_ids[fc[3*pos +: 3]];
      end
      if (i == bad_face)
        q[$urandom_range(0, 3)] = $urandom_range(0, 1) ? vid_t'($urandom)
                                                       : cube_ids[$urandom_range(0, 7)];
      send_face(q[0], q[1], q[2], q[3], 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_noise_cell();
    vid_t q [CORNERS_PER_FACE];
    int   i, k;
    for (i = 0; i < FACES_PER_CELL; i++) begin
      for (k = 0; k < CORNERS_PER_FACE; k++)
        q[k] = ($urandom_range(0, 3) != 0) ? vid_t'($urandom_range(0, 7)) : vid_t'($urandom);
      send_face(q[0], q[1], q[2], q[3], 1'($urandom_range(0, 1)));
    end
  endtask

  // sink side: random pop stalls, none while steady
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (steady) begin
        out_pop <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_pop <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int n_cell, r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clean cube with extreme ids, faces in natural order
    send_face(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0);
    send_face(32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b0);
    send_face(32'h0000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_face(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h0000_0001, 1'b0);
    send_face(32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 1'b0);
    send_face(32'h8000_0000, 32'h5555_5555, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0);
    // same cube from the top face, bottom winding flipped
    send_face(32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b1);
    send_face(32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 1'b0);
    send_face(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b1);
    send_face(32'h0000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_face(32'h8000_0000, 32'h5555_5555, 32'hFFFF_FFFE, 32'h0000_0000, 1'b1);
    send_face(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h0000_0001, 1'b1);
    // corner 1 has several outside neighbours, corner 4 none, repeated ids
    send_face(32'd1,  32'd2,  32'd3,  32'd4,  1'b0);
    send_face(32'd1,  32'd10, 32'd11, 32'd12, 1'b1);
    send_face(32'd1,  32'd20, 32'd21, 32'd22, 1'b0);
    send_face(32'd2,  32'd30, 32'd31, 32'd30, 1'b1);
    send_face(32'd3,  32'd30, 32'd3,  32'd30, 1'b0);
    send_face(32'd5,  32'd6,  32'd7,  32'd8,  1'b1);
    // fully degenerate cell: every edge collapses onto one id
    send_face(32'd9,  32'd9,  32'd9,  32'd9,  1'b1);
    send_face(32'd9,  32'd9,  32'd9,  32'd9,  1'b0);
    send_face(32'd9,  32'd9,  32'd9,  32'd9,  1'b1);
    send_face(32'd9,  32'd9,  32'd9,  32'd9,  1'b0);
    send_face(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    wait_drained();

    for (n_cell = 0; n_cell < 68; n_cell++) begin
      steady = (n_cell >= 30 && n_cell < 38);
      r = $urandom_range(0, 99);
      if (r < 60)      send_cube(1'b0, 1'b0);
      else if (r < 70) send_cube(1'b1, 1'b0);
      else if (r < 85) send_cube(1'b0, 1'b1);
      else             send_noise_cell();
      if (n_cell % 20 == 19) wait_drained();
    end
    steady = 1'b0;

    in_push <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hvo_pkg.sv
rtl/hvo_front.sv
rtl/hvo_fifo.sv
rtl/hvo_back.sv
rtl/hvo_emit.sv
rtl/hexa_vertex_order_unit.sv
bench/hexa_vertex_order_checker.sv
bench/hexa_vertex_order_unit_tb.sv
